// ----- design/pov_pkg.sv -----
`default_nettype none

package pov_pkg;

  // Width of the CORDIC x and y datapath. Both carry 32 fraction bits. The
  // tangent saturates at 2^16, so x stays below 2^49 and 52 signed bits hold
  // every value without overflow.
  localparam int CW = 52;

  // Width of the angle accumulator, signed Q.30.
  localparam int ZW = 32;

  // Width of the saturated tangent, unsigned Q.32, up to and including 2^48.
  localparam int TW = 49;

  // Wide compare width for the raw product before saturation.
  localparam int EW = 64;

  // Scale register width and reset value (unsigned Q4.28).
  localparam int SW = 32;
  localparam logic [SW-1:0] SCALE_RESET = 32'd484315;

  // Output angle width and the clamp at pi/2 in Q2.16.
  localparam int AW = 18;
  localparam logic [AW-1:0] HALF_PI_Q16 = 18'd102944;

  // Rounding constant for Q.30 to Q2.16 and the shift between the two.
  localparam int RND_SHIFT = 14;
  localparam logic [ZW:0] RND_HALF = 33'd8192;

  localparam logic [EW-1:0] TAN_SAT = 64'h0001_0000_0000_0000;
  localparam logic signed [CW-1:0] ONE_Q32 = 52'sh0_0001_0000_0000;

  // atan(2^-i) in Q.30, rounded to nearest.
  localparam logic signed [ZW-1:0] ATAN_Q30 [32] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,
    32'sd64,        32'sd32,        32'sd16,        32'sd8,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  // One item as it moves down the CORDIC chain.
  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } pov_vec_t;

endpackage

`default_nettype wire

// ----- design/pov_tan.sv -----
`default_nettype none

module pov_tan
  import pov_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic [OFFSET_WIDTH-1:0] offset,
  input  wire logic [SW-1:0]           scale,
  output pov_vec_t                     vec
);

  localparam int PW = OFFSET_WIDTH + SW;

  logic                    a_vld_r;
  logic                    a_neg_r;
  logic [OFFSET_WIDTH-1:0] a_mag_r;
  logic                    b_vld_r;
  logic                    b_neg_r;
  logic [PW-1:0]           b_prod_r;
  pov_vec_t                c_vec_r;

  logic                    neg_in;
  logic [EW-1:0]           prod_ext;
  logic [TW-1:0]           tan_sat;

  assign neg_in   = offset[OFFSET_WIDTH-1];
  assign prod_ext = EW'(b_prod_r);
  assign tan_sat  = (prod_ext > TAN_SAT) ? TAN_SAT[TW-1:0] : prod_ext[TW-1:0];

  // Magnitude, then the exact product, then saturation and CORDIC seed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vec_r.vld <= 1'b0;
    end else begin
      a_vld_r     <= take;
      b_vld_r     <= a_vld_r;
      c_vec_r.vld <= b_vld_r;
    end
    a_neg_r      <= neg_in;
    a_mag_r      <= neg_in ? (~offset + 1'b1) : offset;
    b_neg_r      <= a_neg_r;
    b_prod_r     <= PW'(a_mag_r) * PW'(scale);
    c_vec_r.neg  <= b_neg_r;
    c_vec_r.zero <= (tan_sat == '0);
    c_vec_r.x    <= ONE_Q32;
    c_vec_r.y    <= signed'(CW'(tan_sat));
    c_vec_r.z    <= '0;
  end

  assign vec = c_vec_r;

endmodule

`default_nettype wire

// ----- design/pov_cell.sv -----
`default_nettype none

module pov_cell
  import pov_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pov_vec_t vec_i,
  output pov_vec_t      vec_o
);

  pov_vec_t             vec_r;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = vec_i.x >>> IDX;
  assign ys = vec_i.y >>> IDX;

  // One vectoring rotation: drive y toward zero and accumulate the angle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.vld <= 1'b0;
    end else begin
      vec_r.vld <= vec_i.vld;
    end
    vec_r.neg  <= vec_i.neg;
    vec_r.zero <= vec_i.zero;
    if (!vec_i.y[CW-1]) begin
      vec_r.x <= vec_i.x + ys;
      vec_r.y <= vec_i.y - xs;
      vec_r.z <= vec_i.z + ATAN_Q30[IDX];
    end else begin
      vec_r.x <= vec_i.x - ys;
      vec_r.y <= vec_i.y + xs;
      vec_r.z <= vec_i.z - ATAN_Q30[IDX];
    end
  end

  assign vec_o = vec_r;

endmodule

`default_nettype wire

// ----- design/pov_round.sv -----
`default_nettype none

module pov_round
  import pov_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pov_vec_t  vec_i,
  output logic           strobe,
  output logic [AW-1:0]  angle
);

  logic          strobe_r;
  logic [AW-1:0] angle_r;
  logic [ZW:0]   z_clip;
  logic [ZW:0]   z_sum;
  logic [ZW-RND_SHIFT:0] mag_wide;
  logic [AW-1:0] mag;

  always_comb begin
    z_clip   = (vec_i.z[ZW-1] || vec_i.zero) ? '0 : {1'b0, vec_i.z};
    z_sum    = z_clip + RND_HALF;
    mag_wide = z_sum[ZW:RND_SHIFT];
    mag      = (mag_wide > (ZW-RND_SHIFT+1)'(HALF_PI_Q16)) ? HALF_PI_Q16
                                                           : mag_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vec_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= vec_i.neg ? (~mag + 1'b1) : mag;
  end

  assign strobe = strobe_r;
  assign angle  = angle_r;

endmodule

`default_nettype wire

// ----- design/pixel_offset_to_view_angle_core.sv -----
`default_nettype none

// Pixel offset to view angle. Each item is a signed pixel offset from the
// image center (Q12.4 at the default width), and the block returns the
// pinhole line-of-sight angle atan(offset * scale) in signed Q2.16 radians.
// Input: an item is taken at a rising edge with start high and busy low.
// The pipeline never stalls, so busy is high only while reset is asserted
// and an item can be taken in every cycle, one item per clock sustained.
// Output: out_strobe is high for one cycle with out_view_angle; the receiver
// cannot stall and every item yields exactly one result.
// From the accepting edge to the edge that accepts the result, one stage
// forms the magnitude, one the product with the 32-bit scale, one
// saturates it and seeds the CORDIC, one cell runs per CORDIC
// iteration, and one stage rounds, clamps and restores the sign.
// Configuration: cfg_pinhole_scale (unsigned Q4.28) is written when cfg_valid
// and cfg_ready are high; cfg_ready is high whenever reset is released. Write
// it only while no item is in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// scale register to its reset value.
module pixel_offset_to_view_angle_core
  import pov_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 18,
  parameter int OFFSET_WIDTH      = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [OFFSET_WIDTH-1:0] in_pixel_offset,
  output logic                                out_strobe,
  output logic signed [AW-1:0]                out_view_angle,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [SW-1:0]                  cfg_pinhole_scale
);

  localparam int LAT = CORDIC_ITERATIONS + 4;

  logic [SW-1:0] scale_r;
  logic          take;
  logic [AW-1:0] angle;
  pov_vec_t      chain [CORDIC_ITERATIONS+1];

  // The datapath is a free-running pipeline, so it is ready outside reset.
  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_pinhole_scale;
    end
  end

  // Front end: magnitude, exact tangent product, saturation.
  pov_tan #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_tan (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .offset (in_pixel_offset),
    .scale  (scale_r),
    .vec    (chain[0])
  );

  // A row of CORDIC cells; cell i applies the rotation by atan(2^-i).
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    pov_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vec_i (chain[i]),
      .vec_o (chain[i+1])
    );
  end

  // Back end: clip negative angles, round to Q2.16, clamp, restore the sign.
  pov_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .vec_i  (chain[CORDIC_ITERATIONS]),
    .strobe (out_strobe),
    .angle  (angle)
  );

  assign out_view_angle = signed'(angle);

  // Every accepted item produces a matching result strobe.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LAT out_strobe)
    else $error("result missing after accepted item");

  // No result appears without a matching item accepted earlier.
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(take, LAT))
    else $error("result without a matching item");

  // The angle never exceeds pi/2 in magnitude.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_view_angle <= 18'sd102944 && out_view_angle >= -18'sd102944))
    else $error("angle outside +-pi/2");

  // A zero offset maps to a zero angle.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_pixel_offset, LAT) == '0) |-> out_view_angle == '0)
    else $error("zero offset gave nonzero angle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the pixel offset to view angle core.
module testbench
  import pov_pkg::*;
();

  // Pipeline depth from the accepting edge to the result edge.
  localparam int LATENCY = 22;
  localparam int STEPS = 18;
  localparam logic [SW-1:0] SCALE_AT_RESET = 32'd484315;
  localparam longint TAN_LIMIT = 64'h0001_0000_0000_0000;
  localparam longint RIGHT_ANGLE = 102944;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  // atan(2^-i) scaled by 2^30, rounded to nearest.
  localparam longint ARCTAN_STEP [STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192
  };

  // One directed row: the scale to run under, the offset, and an angle that
  // is typed in when the flag is set.
  typedef struct packed {
    logic [SW-1:0]        scale;
    logic signed [15:0]   offset;
    logic                 known;
    logic signed [AW-1:0] angle;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Scale as it comes out of reset.
    '{32'd484315, 16'sh0000, 1'b1, 18'sd0},
    '{32'd484315, 16'sh0001, 1'b0, 18'sd0},
    '{32'd484315, 16'shFFFF, 1'b0, 18'sd0},
    '{32'd484315, 16'sh0010, 1'b0, 18'sd0},
    '{32'd484315, 16'shFFF0, 1'b0, 18'sd0},
    '{32'd484315, 16'sh7FFF, 1'b0, 18'sd0},
    '{32'd484315, 16'sh8000, 1'b0, 18'sd0},
    '{32'd484315, 16'sh5555, 1'b0, 18'sd0},
    '{32'd484315, 16'shAAAA, 1'b0, 18'sd0},
    // A zero scale makes every tangent zero, so every angle is zero.
    '{32'd0, 16'sh7FFF, 1'b1, 18'sd0},
    '{32'd0, 16'sh8000, 1'b1, 18'sd0},
    '{32'd0, 16'sh0001, 1'b1, 18'sd0},
    // Smallest scale: the tiny tangent where the accumulator can end negative.
    '{32'd1, 16'sh0001, 1'b0, 18'sd0},
    '{32'd1, 16'shFFFF, 1'b0, 18'sd0},
    '{32'd1, 16'sh7FFF, 1'b0, 18'sd0},
    '{32'd1, 16'sh8000, 1'b0, 18'sd0},
    // Largest scale: the largest tangents, with angles nearest pi/2.
    '{32'hFFFF_FFFF, 16'sh0001, 1'b0, 18'sd0},
    '{32'hFFFF_FFFF, 16'shFFFF, 1'b0, 18'sd0},
    '{32'hFFFF_FFFF, 16'sh7FFF, 1'b0, 18'sd0},
    '{32'hFFFF_FFFF, 16'sh8000, 1'b0, 18'sd0},
    '{32'hFFFF_FFFF, 16'sh0000, 1'b1, 18'sd0},
    // One pixel at unit scale is a tangent of exactly one, i.e. 45 degrees.
    '{32'h1000_0000, 16'sh0010, 1'b0, 18'sd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [15:0]   in_pixel_offset = '0;
  logic                 out_strobe;
  logic signed [AW-1:0] out_view_angle;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SW-1:0]        cfg_pinhole_scale = '0;

  // Our copy of the scale register, updated on every accepted write.
  logic [SW-1:0] scale_now = SCALE_AT_RESET;
  logic signed [AW-1:0] expected_angles [$];
  int  failures = 0;
  bit  running = 1'b0;

  pixel_offset_to_view_angle_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pixel_offset  (in_pixel_offset),
    .out_strobe       (out_strobe),
    .out_view_angle   (out_view_angle),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pinhole_scale(cfg_pinhole_scale)
  );

  always #2 clk = ~clk;

  // The angle for one offset: the exact tangent |offset| * scale is
  // saturated, run through a vectoring CORDIC, rounded half up to Q2.16,
  // clamped at pi/2 and given the sign of the offset.
  function automatic logic signed [AW-1:0] predict_view_angle(
    input logic signed [15:0] offset,
    input logic [SW-1:0]      scale
  );
    logic [15:0] mag;
    logic [63:0] tangent;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      ang;
    mag = offset[15] ? (~offset + 16'd1) : offset;
    tangent = {48'd0, mag} * {32'd0, scale};
    if (tangent > TAN_LIMIT) begin
      tangent = TAN_LIMIT;
    end
    x = longint'(1) << 32;
    y = longint'(tangent);
    z = 0;
    // Arithmetic shifts floor toward minus infinity, as the datapath does.
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN_STEP[i];
      end
      x = nx;
    end
    // A tiny tangent can leave the accumulator slightly below zero.
    if (z < 0 || tangent == 0) begin
      z = 0;
    end
    ang = (z + 8192) >>> 14;
    if (ang > RIGHT_ANGLE) begin
      ang = RIGHT_ANGLE;
    end
    if (offset[15]) begin
      ang = -ang;
    end
    return ang[AW-1:0];
  endfunction

  // Half the offsets span the whole range so every bit toggles; the rest sit
  // near zero, where the small-angle rounding lives, or at the extremes.
  function automatic logic signed [15:0] pick_offset();
    int unsigned pick;
    logic signed [15:0] mag;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return 16'($urandom);
    end else if (pick < 8) begin
      mag = 16'($urandom_range(0, 64));
      return $urandom_range(0, 1) ? -mag : mag;
    end else begin
      case ($urandom_range(0, 4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'sh0001;
        default: return 16'shFFFF;
      endcase
    end
  endfunction

  // Scales: realistic field-of-view values, tiny ones, near-maximum ones and
  // fully random words.
  function automatic logic [SW-1:0] pick_scale();
    case ($urandom_range(0, 3))
      0: return 32'($urandom);
      1: return 32'($urandom_range(1 << 12, 1 << 22));
      2: return 32'($urandom_range(1, 16));
      default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
    endcase
  endfunction

  // Gap before the next item: mostly none or short, now and then long.
  function automatic int pick_gap(input bit burst);
    int unsigned roll;
    if (burst) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 9);
    end
    return $urandom_range(10, 40);
  endfunction

  // Present one offset from a falling edge and hold it until the core takes
  // it. Returns just after the accepting rising edge.
  task automatic send_offset(
    input logic signed [15:0]   offset,
    input logic                 known,
    input logic signed [AW-1:0] typed_angle
  );
    start <= 1'b1;
    in_pixel_offset <= offset;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    if (known) begin
      expected_angles.push_back(typed_angle);
    end else begin
      expected_angles.push_back(predict_view_angle(offset, scale_now));
    end
  endtask

  // Move to the next falling edge and, for a nonzero gap, drop start for
  // the length of the gap. A zero gap keeps start high for back-to-back items.
  task automatic idle_sender(input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the sender off until every item in flight has come back. The wait
  // always crosses a falling edge, so start is never lowered and raised in one step.
  task automatic drain_results();
    start <= 1'b0;
    do begin
      @(negedge clk);
    end while (expected_angles.size() != 0);
  endtask

  // The scale may only change with the pipeline empty.
  task automatic write_scale(input logic [SW-1:0] scale);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_pinhole_scale <= scale;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    scale_now = scale;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every strobe must match the angle of the oldest outstanding item.
  always @(posedge clk) begin
    if (running && out_strobe !== 1'b0) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual view_angle %0d",
                 $realtime, out_view_angle);
        failures++;
      end else begin
        if (out_view_angle !== expected_angles[0]) begin
          $display("%0t: view_angle mismatch, expected %0d, actual %0d",
                   $realtime, expected_angles[0], out_view_angle);
          failures++;
        end
        void'(expected_angles.pop_front());
      end
    end
  end

  // Generous cap on the run; a correct run ends far earlier.
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int drain_at;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    running = 1'b1;
    @(negedge clk);

    // Directed part: the scale is rewritten whenever a row asks for a new one.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].scale != scale_now) begin
        write_scale(DIRECTED[r].scale);
      end
      send_offset(DIRECTED[r].offset, DIRECTED[r].known, DIRECTED[r].angle);
      idle_sender($urandom_range(0, 2));
    end

    // Random part in phases, one scale per phase. The first two phases pin
    // the smallest nonzero and the largest scale, the third the reset value.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_scale(32'd1);
        1: write_scale(32'hFFFF_FFFF);
        2: write_scale(SCALE_AT_RESET);
        default: write_scale(pick_scale());
      endcase
      drain_at = $urandom_range(60, ITEMS_PER_PHASE - 20);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_offset(pick_offset(), 1'b0, '0);
        // The first stretch of every phase runs at full rate.
        idle_sender(pick_gap(n < 50));
        if (n == drain_at) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (2 * LATENCY) @(negedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pov_pkg.sv
design/pov_tan.sv
design/pov_cell.sv
design/pov_round.sv
design/pixel_offset_to_view_angle_core.sv
tb/testbench.sv
